// ===== design/tmie_pkg.sv =====
// ----------------------------------------------------------------------------
// tmie_pkg : shared types and constants of the tape machine executor
// Op codes, field widths and the tape port control group.
// ----------------------------------------------------------------------------
package tmie_pkg;

   localparam int OP_BITS       = 3;
   localparam int AMOUNT_BITS   = 16;
   localparam int PC_FIELD_BITS = 16;
   localparam int BYTE_BITS     = 8;
   localparam int REPEAT_BITS   = 15;

   // op code 7 is unused and runs as halt
   typedef enum logic [OP_BITS-1:0] {
      OP_MOVE   = 3'd0,
      OP_ADJUST = 3'd1,
      OP_OPEN   = 3'd2,
      OP_CLOSE  = 3'd3,
      OP_PUT    = 3'd4,
      OP_GET    = 3'd5,
      OP_HALT   = 3'd6
   } op_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tape_ctl_type;

endpackage

// ===== design/tmie_tape.sv =====
// ----------------------------------------------------------------------------
// tmie_tape : byte tape store
// Single-port-write, registered-read memory with a write-to-read bypass and
// a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tmie_tape #(
   parameter  int CELLS     = 32768,
   localparam int ADDR_BITS = $clog2(CELLS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tmie_pkg::tape_ctl_type        ctl,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic [tmie_pkg::BYTE_BITS-1:0] wr_data,
   output logic [tmie_pkg::BYTE_BITS-1:0] rd_data,
   output logic                          busy
);
   import tmie_pkg::*;

   logic [BYTE_BITS-1:0] mem_ff [CELLS];
   logic [BYTE_BITS-1:0] q_ff;
   logic [BYTE_BITS-1:0] fwd_data_ff;
   logic                 fwd_hit_ff;
   logic                 busy_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic                 clr_last;

   assign clr_last = (clr_addr_ff == ADDR_BITS'(CELLS - 1));

   // clearing sweep and bypass flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (busy_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
            if (clr_last) begin
               busy_ff <= 1'b0;
            end
         end
         if (ctl.rd_en) begin
            // same-edge write is missed by the read, so remember it
            fwd_hit_ff <= ctl.wr_en && (wr_addr == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         q_ff        <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : q_ff;
   assign busy    = busy_ff;

`ifndef NO_ASSERTIONS
   a_idle_while_clearing : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (!ctl.rd_en && !ctl.wr_en))
      else $error("tape accessed during clearing sweep");

   a_sweep_complete : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(clr_addr_ff) == ADDR_BITS'(CELLS - 1)))
      else $error("clearing sweep ended early");

   a_reset_starts_sweep : assert property (@(posedge clock)
      reset |=> (busy_ff && clr_addr_ff == '0))
      else $error("reset did not start clearing sweep");
`endif

endmodule

// ===== design/tape_machine_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor : byte-tape machine, one instruction a word
// Runs decoded run-length instructions against a byte tape and a cell pointer.
// ----------------------------------------------------------------------------
// Usage
//   req channel : one decoded instruction per word (op on req_tuser).
//   rsp channel : one result word per instruction; rsp_tlast flags halt.
//   Pipeline of four stages:
//     S1  pointer offset reduced by reciprocal multiply (quotient)
//     S2  remainder; cell pointer updated, tape read issued
//     S3  execute: read-modify-write of the current cell
//     OUT result register
//   Throughput: one word per cycle while rsp_tready is high, set by the S3 tape
//   read-modify-write; a write in S3 is bypassed to the read of the following word.
//   Reset: a clearing sweep zeroes the tape, one cell a cycle, across all
//   TAPE_CELLS cells; req_tready stays low until it finishes.
//   Stall: when rsp_tready is low, stages behind the result register keep
//   filling, so up to four words are held before req_tready drops.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor #(
   parameter int TAPE_CELLS = 32768,
   parameter int PC_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // amount[15:0], jump_target[31:16], pc[47:32],
                                    // in_byte[55:48]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // next_pc[15:0], out_byte[23:16],
                                    // out_repeat[38:24], zero[39]
   output logic        rsp_tlast    // halted
);
   import tmie_pkg::*;

   localparam int    PTR_BITS   = $clog2(TAPE_CELLS);
   localparam int    U_BITS     = AMOUNT_BITS + 1;
   // multiple of the tape size that lifts any amount to a non-negative value
   localparam int    HALF_SPAN  = 1 << (AMOUNT_BITS - 1);
   localparam int    OFFSET     = TAPE_CELLS * ((HALF_SPAN + TAPE_CELLS - 1) / TAPE_CELLS);
   localparam int    SHIFT      = 2 * U_BITS;
   localparam longint RECIP     = ((longint'(1) << SHIFT) + TAPE_CELLS - 1) / TAPE_CELLS;
   localparam int    RECIP_BITS = $clog2(RECIP + 1);
   localparam int    PROD_BITS  = U_BITS + RECIP_BITS;
   localparam int    Q_BITS     = $clog2((1 << U_BITS) / TAPE_CELLS + 1);
   localparam int    PC_KEEP    = (PC_BITS < PC_FIELD_BITS) ? PC_BITS : PC_FIELD_BITS;
   localparam logic [PC_FIELD_BITS-1:0] PC_MASK =
      PC_FIELD_BITS'((longint'(1) << PC_KEEP) - 1);
   localparam logic [PTR_BITS:0] CELLS_EXT = (PTR_BITS + 1)'(TAPE_CELLS);

   // ---------------- handshake chain ----------------
   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic ready1, ready2, ready3, ready_o;
   logic t0, t2, t3;
   logic tape_busy;

   assign ready_o    = !vo_ff || rsp_tready;
   assign ready3     = !v3_ff || ready_o;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1 && !tape_busy;
   assign t0         = req_tvalid && req_tready;
   assign t2         = v2_ff && ready3;
   assign t3         = v3_ff && ready_o;

   // ---------------- S0: offset and quotient ----------------
   logic signed [AMOUNT_BITS-1:0] req_amount;
   logic [U_BITS-1:0]             u_in;
   logic [PROD_BITS-1:0]          prod;
   logic [Q_BITS-1:0]             q_in;

   assign req_amount = req_tdata[15:0];
   assign u_in       = U_BITS'(32'(req_amount) + 32'(OFFSET));
   assign prod       = PROD_BITS'(u_in) * PROD_BITS'(RECIP);
   assign q_in       = prod[SHIFT +: Q_BITS];

   // ---------------- S1 ----------------
   op_type                          op1_ff;
   logic signed [AMOUNT_BITS-1:0]   amt1_ff;
   logic [PC_FIELD_BITS-1:0]        tgt1_ff, pc1_ff;
   logic [BYTE_BITS-1:0]            byte1_ff;
   logic [U_BITS-1:0]               u1_ff;
   logic [Q_BITS-1:0]               q1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= t0;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         op1_ff   <= op_type'(req_tuser);
         amt1_ff  <= req_amount;
         tgt1_ff  <= req_tdata[31:16];
         pc1_ff   <= req_tdata[47:32];
         byte1_ff <= req_tdata[55:48];
         u1_ff    <= u_in;
         q1_ff    <= q_in;
      end
   end

   // ---------------- S1 -> S2: remainder ----------------
   logic [U_BITS-1:0]   qt;
   logic [U_BITS-1:0]   rem_wide;
   logic [PTR_BITS-1:0] r_in;

   assign qt       = U_BITS'(U_BITS'(q1_ff) * U_BITS'(TAPE_CELLS));
   assign rem_wide = u1_ff - qt;
   assign r_in     = rem_wide[PTR_BITS-1:0];

   op_type                          op2_ff;
   logic signed [AMOUNT_BITS-1:0]   amt2_ff;
   logic [PC_FIELD_BITS-1:0]        tgt2_ff, pc2_ff;
   logic [BYTE_BITS-1:0]            byte2_ff;
   logic [PTR_BITS-1:0]             r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         op2_ff   <= op1_ff;
         amt2_ff  <= amt1_ff;
         tgt2_ff  <= tgt1_ff;
         pc2_ff   <= pc1_ff;
         byte2_ff <= byte1_ff;
         r2_ff    <= r_in;
      end
   end

   // ---------------- S2: cell pointer, tape read ----------------
   logic [PTR_BITS-1:0] ptr_ff, ptr_in;
   logic [PTR_BITS:0]   ptr_sum;

   assign ptr_sum = (PTR_BITS + 1)'(ptr_ff) + (PTR_BITS + 1)'(r2_ff);
   assign ptr_in  = (ptr_sum >= CELLS_EXT) ? PTR_BITS'(ptr_sum - CELLS_EXT)
                                           : PTR_BITS'(ptr_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (t2 && op2_ff == OP_MOVE) begin
         ptr_ff <= ptr_in;
      end
   end

   op_type                          op3_ff;
   logic signed [AMOUNT_BITS-1:0]   amt3_ff;
   logic [PC_FIELD_BITS-1:0]        tgt3_ff, pc3_ff;
   logic [BYTE_BITS-1:0]            byte3_ff;
   logic [PTR_BITS-1:0]             addr3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         op3_ff   <= op2_ff;
         amt3_ff  <= amt2_ff;
         tgt3_ff  <= tgt2_ff;
         pc3_ff   <= pc2_ff;
         byte3_ff <= byte2_ff;
         addr3_ff <= ptr_ff;
      end
   end

   // ---------------- S3: execute ----------------
   tape_ctl_type             tape_ctl;
   logic [BYTE_BITS-1:0]     cur_byte;
   logic [BYTE_BITS-1:0]     wr_data;
   logic                     wr_req;
   logic                     amt_pos;
   logic [PC_FIELD_BITS-1:0] pc_inc, tgt_inc;
   logic [PC_FIELD_BITS-1:0] next_pc_in;
   logic [BYTE_BITS-1:0]     out_byte_in;
   logic [REPEAT_BITS-1:0]   out_repeat_in;
   logic                     halted_in;

   assign amt_pos = !amt3_ff[AMOUNT_BITS-1] && (amt3_ff != '0);
   assign pc_inc  = (pc3_ff + PC_FIELD_BITS'(1)) & PC_MASK;
   assign tgt_inc = (tgt3_ff + PC_FIELD_BITS'(1)) & PC_MASK;

   always_comb begin
      next_pc_in    = pc_inc;
      out_byte_in   = '0;
      out_repeat_in = '0;
      halted_in     = 1'b0;
      wr_req        = 1'b0;
      wr_data       = cur_byte;
      case (op3_ff)
         OP_MOVE: begin
         end
         OP_ADJUST: begin
            wr_req  = 1'b1;
            wr_data = cur_byte + amt3_ff[BYTE_BITS-1:0];
         end
         OP_OPEN: begin
            if (cur_byte == '0) begin
               next_pc_in = tgt_inc;
            end
         end
         OP_CLOSE: begin
            if (cur_byte != '0) begin
               next_pc_in = tgt_inc;
            end
         end
         OP_PUT: begin
            out_byte_in = cur_byte;
            if (amt_pos) begin
               out_repeat_in = amt3_ff[REPEAT_BITS-1:0];
            end
         end
         OP_GET: begin
            // a non-positive count leaves the cell alone
            wr_req  = amt_pos;
            wr_data = byte3_ff;
         end
         default: begin
            // halt and the unused code: hold pc, flag the end
            next_pc_in = pc3_ff & PC_MASK;
            halted_in  = 1'b1;
         end
      endcase
   end

   assign tape_ctl.rd_en = t2;
   assign tape_ctl.wr_en = t3 && wr_req;

   tmie_tape #(
      .CELLS (TAPE_CELLS)
   ) u_tape (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tape_ctl),
      .rd_addr (ptr_ff),
      .wr_addr (addr3_ff),
      .wr_data (wr_data),
      .rd_data (cur_byte),
      .busy    (tape_busy)
   );

   // ---------------- result register ----------------
   logic [PC_FIELD_BITS-1:0] next_pc_ff;
   logic [BYTE_BITS-1:0]     out_byte_ff;
   logic [REPEAT_BITS-1:0]   out_repeat_ff;
   logic                     halted_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (ready_o) begin
         vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o) begin
         next_pc_ff    <= next_pc_in;
         out_byte_ff   <= out_byte_in;
         out_repeat_ff <= out_repeat_in;
         halted_ff     <= halted_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {1'b0, out_repeat_ff, out_byte_ff, next_pc_ff};
   assign rsp_tlast  = halted_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      tape_busy |-> !req_tready)
      else $error("word accepted during tape clearing");

   a_pointer_in_range : assert property (@(posedge clock) disable iff (reset)
      (PTR_BITS + 1)'(ptr_ff) < CELLS_EXT)
      else $error("cell pointer beyond tape");

   a_halt_emits_nothing : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[38:16] == '0))
      else $error("halt word carries output data");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the tape machine instruction executor
// Streams decoded instructions through the req channel and checks every rsp
// word against a behavioural predictor. The predictor keeps its own tape and
// cell pointer. A short directed burst covers pointer wrap, branch pc wrap,
// zero and negative counts and halt. Then about two thousand random words
// follow: mostly program-like fragments that stay near a few cells, plus
// full-range noise. Both sides idle at random, and the receiver is held off
// once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import tmie_pkg::*;

   localparam int TAPE_CELLS      = 32768;
   localparam int PC_BITS         = 16;
   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 5;
   localparam int RANDOM_WORDS    = 1950;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 16;     // pipeline holds four words, keep a margin
   localparam int REPORT_LIMIT    = 10;
   // clearing sweep, plus every word paying the longest gap, stall and latency,
   // then taken several times over
   localparam int LIMIT_CYCLES    = 1_000_000;

   // spare op code, executes as halt
   localparam logic [OP_BITS-1:0] OP_SPARE = 3'd7;

   typedef struct {
      logic [PC_FIELD_BITS-1:0] next_pc;
      logic [BYTE_BITS-1:0]     out_byte;
      logic [REPEAT_BITS-1:0]   out_repeat;
      logic                     halted;
   } outcome_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts each outcome as the word is accepted and holds it
   // until the matching rsp word turns up.
   // -------------------------------------------------------------------------
   class instr_scoreboard;
      logic [BYTE_BITS-1:0] tape_cells [TAPE_CELLS];
      int                   cell_ptr;
      outcome_type          expected_outcomes [$];
      int                   failures;
      int                   words_noted;
      int                   outcomes_checked;
      int                   op_counts [8];

      function new();
         foreach (tape_cells[i]) tape_cells[i] = '0;
         cell_ptr = 0;
         failures = 0;
         words_noted = 0;
         outcomes_checked = 0;
         foreach (op_counts[i]) op_counts[i] = 0;
      endfunction

      function int pending();
         return expected_outcomes.size();
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      // one instruction against the local tape and pointer
      function outcome_type execute_instr(logic [OP_BITS-1:0] op_code,
                                          logic signed [AMOUNT_BITS-1:0] amount,
                                          logic [PC_FIELD_BITS-1:0] target,
                                          logic [PC_FIELD_BITS-1:0] pc,
                                          logic [BYTE_BITS-1:0] in_byte);
         outcome_type res;
         int          sum;
         res.next_pc    = pc + 16'd1;
         res.out_byte   = '0;
         res.out_repeat = '0;
         res.halted     = 1'b0;
         case (op_code)
            OP_MOVE: begin
               // true modulo: negative sums wrap down from cell 0
               sum = (cell_ptr + int'(amount)) % TAPE_CELLS;
               if (sum < 0) sum += TAPE_CELLS;
               cell_ptr = sum;
            end
            OP_ADJUST: tape_cells[cell_ptr] = tape_cells[cell_ptr] + amount[BYTE_BITS-1:0];
            OP_OPEN: begin
               if (tape_cells[cell_ptr] == '0) res.next_pc = target + 16'd1;
            end
            OP_CLOSE: begin
               if (tape_cells[cell_ptr] != '0) res.next_pc = target + 16'd1;
            end
            OP_PUT: begin
               res.out_byte = tape_cells[cell_ptr];
               if (amount > 0) res.out_repeat = amount[REPEAT_BITS-1:0];
            end
            OP_GET: begin
               if (amount > 0) tape_cells[cell_ptr] = in_byte;
            end
            default: begin
               // halt and the spare code: pc holds, state untouched
               res.next_pc = pc;
               res.halted  = 1'b1;
            end
         endcase
         return res;
      endfunction

      function void note_input(logic [OP_BITS-1:0] op_code,
                               logic signed [AMOUNT_BITS-1:0] amount,
                               logic [PC_FIELD_BITS-1:0] target,
                               logic [PC_FIELD_BITS-1:0] pc,
                               logic [BYTE_BITS-1:0] in_byte);
         words_noted++;
         op_counts[op_code]++;
         expected_outcomes.push_back(execute_instr(op_code, amount, target, pc, in_byte));
      endfunction

      function void check_result(logic [39:0] data, logic last);
         outcome_type want;
         outcome_type got;
         got.next_pc    = data[15:0];
         got.out_byte   = data[23:16];
         got.out_repeat = data[38:24];
         got.halted     = last;
         if (expected_outcomes.size() == 0) begin
            flag($sformatf("rsp word with nothing outstanding: next_pc %h byte %h rep %h halt %b",
                           got.next_pc, got.out_byte, got.out_repeat, got.halted));
            return;
         end
         want = expected_outcomes.pop_front();
         outcomes_checked++;
         if (got.next_pc !== want.next_pc || got.out_byte !== want.out_byte ||
             got.out_repeat !== want.out_repeat || got.halted !== want.halted) begin
            flag($sformatf({"rsp word %0d: expected next_pc %h byte %h rep %h halt %b,",
                            " got next_pc %h byte %h rep %h halt %b"},
                           outcomes_checked, want.next_pc, want.out_byte, want.out_repeat,
                           want.halted, got.next_pc, got.out_byte, got.out_repeat,
                           got.halted));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals; every input known from time zero
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // amount, jump_target, pc, in_byte
   logic [2:0]  req_tuser  = '0;   // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // next_pc, out_byte, out_repeat, zero
   logic        rsp_tlast;         // halted

   instr_scoreboard sb;

   // program-fragment state, and idling controls shared between processes
   logic [PC_FIELD_BITS-1:0] prog_pc = '0;
   bit                       no_idle = 1'b0;
   int                       hold_off_asked = 0;
   int                       hold_off_done  = 0;

   tape_machine_instruction_executor #(
      .TAPE_CELLS (TAPE_CELLS),
      .PC_BITS    (PC_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // -------------------------------------------------------------------------
   // Monitor: samples both handshakes at the edge, before any driver update.
   // Results are checked before the new word is noted; a result is registered
   // after its word is accepted, so the order does not matter for matching.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_input(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                          req_tdata[55:48]);
      end
   end

   // mostly short gaps, a few long ones, none during a quiet stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Receiver: random stalls, and a long hold-off on request, counted here
   // so the sender keeps pushing words while the pipeline backs up.
   // -------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_done < hold_off_asked) begin
            hold_off_done++;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks. Each is entered just after a rising edge and returns at
   // the edge where its word was taken, so valid is never dropped and raised
   // in one step.
   // -------------------------------------------------------------------------
   task automatic send_word(logic [OP_BITS-1:0] op_code, logic [15:0] amount,
                            logic [15:0] target, logic [15:0] pc, logic [7:0] in_byte);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op_code;
      req_tdata  <= {in_byte, pc, target, amount};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // pause the sender until every predicted result has been seen
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   // run counts stay small so the pointer lingers over a handful of cells and
   // branches see both zero and nonzero; one in ten goes full range
   function automatic logic [15:0] run_count(int lo, int hi);
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, hi - lo) + lo);
   endfunction

   task automatic send_program_word();
      logic [OP_BITS-1:0] op_code;
      logic [15:0]        amount;
      logic [15:0]        target;
      logic [7:0]         in_byte;
      int                 r;
      r       = $urandom_range(0, 99);
      target  = prog_pc + 16'($urandom_range(0, 20)) - 16'd10;
      // the host hands over zero once its input has run dry
      in_byte = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
      if (r < 25) begin
         op_code = OP_MOVE;
         amount  = run_count(-4, 4);
      end else if (r < 50) begin
         op_code = OP_ADJUST;
         amount  = run_count(-3, 3);
      end else if (r < 60) begin
         op_code = OP_OPEN;
         amount  = 16'($urandom);
      end else if (r < 70) begin
         op_code = OP_CLOSE;
         amount  = 16'($urandom);
      end else if (r < 82) begin
         op_code = OP_PUT;
         amount  = run_count(-1, 5);
      end else if (r < 97) begin
         op_code = OP_GET;
         amount  = run_count(-1, 2);
      end else begin
         op_code = ($urandom_range(0, 1) == 0) ? OP_HALT : OP_SPARE;
         amount  = 16'($urandom);
      end
      send_word(op_code, amount, target, prog_pc, in_byte);
      // an occasional taken branch lands somewhere else in the program
      if ($urandom_range(0, 9) == 0) prog_pc = 16'($urandom);
      else prog_pc = prog_pc + 16'd1;
   endtask

   task automatic send_noise_word();
      send_word(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // req_tready stays low through the tape clearing sweep; send_word waits

      // directed words, pointer starts at cell 0, tape clear
      send_word(OP_MOVE,   16'hFFFF, 16'h0000, 16'h0000, 8'h00); // 0 - 1 wraps to top cell
      send_word(OP_ADJUST, 16'hFFFF, 16'h0000, 16'h0001, 8'h00); // cell becomes 0xff
      send_word(OP_PUT,    16'h0000, 16'h0000, 16'h0002, 8'h00); // zero count, byte shown
      send_word(OP_PUT,    16'h7FFF, 16'h0000, 16'h0003, 8'h00); // largest repeat
      send_word(OP_PUT,    16'h8000, 16'h0000, 16'h0004, 8'h00); // most negative count
      send_word(OP_OPEN,   16'h0000, 16'hFFFF, 16'h0005, 8'h00); // nonzero: falls through
      send_word(OP_CLOSE,  16'h0000, 16'hFFFF, 16'h0064, 8'h00); // taken, target+1 wraps
      send_word(OP_MOVE,   16'h0001, 16'h0000, 16'h0000, 8'h00); // top cell + 1 wraps to 0
      send_word(OP_OPEN,   16'h0000, 16'hFFFF, 16'h0001, 8'h00); // zero cell: taken, wraps
      send_word(OP_CLOSE,  16'h0000, 16'h1234, 16'hFFFF, 8'h00); // not taken, pc+1 wraps
      send_word(OP_GET,    16'h0000, 16'h0000, 16'h0002, 8'hFF); // zero count: no store
      send_word(OP_GET,    16'h8000, 16'h0000, 16'h0003, 8'hFF); // negative count: no store
      send_word(OP_PUT,    16'h0001, 16'h0000, 16'h0004, 8'h00); // still zero
      send_word(OP_GET,    16'h0001, 16'h0000, 16'h0005, 8'hFF); // stores 0xff
      send_word(OP_ADJUST, 16'h7FFF, 16'h0000, 16'h0006, 8'h00); // low byte 0xff added
      send_word(OP_ADJUST, 16'h8000, 16'h0000, 16'h0007, 8'h00); // low byte zero
      send_word(OP_PUT,    16'h0003, 16'h0000, 16'h0008, 8'h00);
      send_word(OP_GET,    16'h7FFF, 16'h0000, 16'h0009, 8'h00); // input ran dry: zero
      send_word(OP_CLOSE,  16'h0000, 16'h0000, 16'h000A, 8'h00);
      send_word(OP_MOVE,   16'h7FFF, 16'h0000, 16'h000B, 8'h00); // largest forward move
      send_word(OP_MOVE,   16'h8000, 16'h0000, 16'h000C, 8'h00); // largest backward move
      send_word(OP_PUT,    16'h0002, 16'h0000, 16'h000D, 8'h00); // top cell kept 0xff
      send_word(OP_HALT,   16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF); // pc holds at the top
      send_word(OP_SPARE,  16'h0000, 16'h0000, 16'h0000, 8'h00); // spare code halts
      send_word(OP_MOVE,   16'h0000, 16'h0000, 16'h0001, 8'h00);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (n == 300) begin
            // long receiver hold-off with the sender pushing flat out
            no_idle = 1'b1;
            hold_off_asked++;
         end
         if (n == 1000) wait_drained();
         if ($urandom_range(0, 99) < 85) send_program_word();
         else send_noise_word();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d words: move %0d, adjust %0d, open %0d, close %0d, put %0d, get %0d,",
               sb.words_noted, sb.op_counts[OP_MOVE], sb.op_counts[OP_ADJUST],
               sb.op_counts[OP_OPEN], sb.op_counts[OP_CLOSE], sb.op_counts[OP_PUT],
               sb.op_counts[OP_GET]);
      $display("halt %0d, spare %0d; %0d results checked, incl. pointer wrap and %0d-cycle hold-off",
               sb.op_counts[OP_HALT], sb.op_counts[OP_SPARE], sb.outcomes_checked,
               HOLD_OFF_CYCLES);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failure(s), %0d result(s) never arrived", sb.failures, sb.pending());
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("Timed out after %0d cycles", LIMIT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tmie_pkg.sv
design/tmie_tape.sv
design/tape_machine_instruction_executor.sv
verif/testbench.sv
